@@ design/smm_pkg.sv @@
// ----------------------------------------------------------------------------
// smm_pkg
// Shared types and constants of the square matrix multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package smm_pkg;

    localparam int MAX_DIM = 8;
    localparam int DIM_W   = 3;
    localparam int ADDR_W  = 2 * DIM_W;
    localparam int CELLS   = MAX_DIM * MAX_DIM;
    localparam int DATA_W  = 32;
    localparam int KIND_W  = 2;
    localparam int SIZE_W  = 4;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_DIM);

    localparam logic [KIND_W-1:0] KIND_LOAD_A  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_B  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [DIM_W-1:0]         elem_row;
        logic [DIM_W-1:0]         elem_col;
        logic signed [DATA_W-1:0] elem_value;
    } t_in;

    typedef struct packed {
        logic [DIM_W-1:0]         out_row;
        logic [DIM_W-1:0]         out_col;
        logic signed [DATA_W-1:0] out_value;
        logic                     last_result;
    } t_out;

    typedef struct packed {
        logic we_a;
        logic we_b;
    } t_load_cmd;

    typedef struct packed {
        logic             valid;
        logic [DIM_W-1:0] i;
        logic [DIM_W-1:0] j;
        logic [DIM_W-1:0] k;
        logic             first;
        logic             last_k;
        logic             last_all;
    } t_cmd;

    typedef struct packed {
        logic pipe_busy;
    } t_dp_status;

endpackage

`default_nettype wire

@@ design/smm_ram.sv @@
// ----------------------------------------------------------------------------
// smm_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module smm_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ design/smm_ctrl.sv @@
// ----------------------------------------------------------------------------
// smm_ctrl
// Controller: size register, request decode and the i/j/k sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module smm_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [smm_pkg::KIND_W-1:0]   i_kind,
    input  wire logic                         i_cfg_we,
    input  wire logic [smm_pkg::SIZE_W-1:0]   i_cfg_wdata,
    input  wire smm_pkg::t_dp_status          i_status,
    output logic                              o_busy,
    output smm_pkg::t_load_cmd                o_load,
    output smm_pkg::t_cmd                     o_cmd
);

    import smm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    t_state            r_state, n_state;
    logic [SIZE_W-1:0] r_size, n_size;
    logic [DIM_W-1:0]  r_dim_max, n_dim_max;
    t_cmd              r_cmd, n_cmd;

    logic              w_accept;
    logic [DIM_W-1:0]  w_cfg_max;
    logic [DIM_W-1:0]  w_k, w_j, w_i;
    logic              w_k_last, w_j_last;

    assign w_accept = i_start && (r_state == ST_IDLE);

    always_comb begin
        if (r_size == '0) begin
            w_cfg_max = '0;
        end else if (32'(r_size) > MAX_DIM) begin
            w_cfg_max = DIM_W'(MAX_DIM - 1);
        end else begin
            w_cfg_max = DIM_W'(r_size - 1'b1);
        end
    end

    always_comb begin
        o_load = '0;
        if (w_accept) begin
            unique case (i_kind)
                KIND_LOAD_A: o_load.we_a = 1'b1;
                KIND_LOAD_B: o_load.we_b = 1'b1;
                default:     o_load = '0;
            endcase
        end
    end

    assign w_k_last = (r_cmd.k == r_dim_max);
    assign w_j_last = (r_cmd.j == r_dim_max);

    always_comb begin
        w_k = r_cmd.k;
        w_j = r_cmd.j;
        w_i = r_cmd.i;
        if (!w_k_last) begin
            w_k = DIM_W'(r_cmd.k + 1'b1);
        end else begin
            w_k = '0;
            if (w_j_last) begin
                w_j = '0;
                w_i = DIM_W'(r_cmd.i + 1'b1);
            end else begin
                w_j = DIM_W'(r_cmd.j + 1'b1);
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_size    = r_size;
        n_dim_max = r_dim_max;
        n_cmd     = r_cmd;
        if (i_cfg_we) begin
            n_size = i_cfg_wdata;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_kind == KIND_COMPUTE)) begin
                    n_state        = ST_RUN;
                    n_dim_max      = w_cfg_max;
                    n_cmd.valid    = 1'b1;
                    n_cmd.i        = '0;
                    n_cmd.j        = '0;
                    n_cmd.k        = '0;
                    n_cmd.first    = 1'b1;
                    n_cmd.last_k   = (w_cfg_max == '0);
                    n_cmd.last_all = (w_cfg_max == '0);
                end
            end
            ST_RUN: begin
                if (r_cmd.last_all) begin
                    n_state     = ST_DRAIN;
                    n_cmd.valid = 1'b0;
                end else begin
                    n_cmd.i        = w_i;
                    n_cmd.j        = w_j;
                    n_cmd.k        = w_k;
                    n_cmd.first    = w_k_last;
                    n_cmd.last_k   = (w_k == r_dim_max);
                    n_cmd.last_all = (w_k == r_dim_max) && (w_j == r_dim_max)
                                     && (w_i == r_dim_max);
                end
            end
            ST_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state     = ST_IDLE;
                n_cmd.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_size      <= SIZE_RESET;
            r_dim_max   <= '0;
            r_cmd.valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_size    <= n_size;
            r_dim_max <= n_dim_max;
            r_cmd     <= n_cmd;
        end
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_cmd  = r_cmd;

endmodule

`default_nettype wire

@@ design/smm_datapath.sv @@
// ----------------------------------------------------------------------------
// smm_datapath
// Matrix stores, multiplier, accumulator and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module smm_datapath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire smm_pkg::t_load_cmd i_load,
    input  wire smm_pkg::t_in       i_in,
    input  wire smm_pkg::t_cmd      i_cmd,
    output smm_pkg::t_dp_status     o_status,
    output logic                    o_strobe,
    output smm_pkg::t_out           o_result
);

    import smm_pkg::*;

    logic [ADDR_W-1:0] w_waddr;
    logic              w_in_range;
    logic [DATA_W-1:0] w_a_rdata, w_b_rdata;
    logic [DATA_W-1:0] w_sum;

    t_cmd              r_s1, r_s2;
    logic [DATA_W-1:0] r_prod;
    logic [DATA_W-1:0] r_acc;
    logic              r_strobe;
    t_out              r_result;

    assign w_waddr    = {i_in.elem_row, i_in.elem_col};
    assign w_in_range = (32'(i_in.elem_row) < MAX_DIM) && (32'(i_in.elem_col) < MAX_DIM);

    smm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CELLS)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (i_load.we_a && w_in_range),
        .i_waddr (w_waddr),
        .i_wdata (i_in.elem_value),
        .i_re    (i_cmd.valid),
        .i_raddr ({i_cmd.i, i_cmd.k}),
        .o_rdata (w_a_rdata)
    );

    smm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CELLS)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (i_load.we_b && w_in_range),
        .i_waddr (w_waddr),
        .i_wdata (i_in.elem_value),
        .i_re    (i_cmd.valid),
        .i_raddr ({i_cmd.k, i_cmd.j}),
        .o_rdata (w_b_rdata)
    );

    assign w_sum = (r_s2.first ? '0 : r_acc) + r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_s1     <= i_cmd;
            r_s2     <= r_s1;
            r_strobe <= r_s2.valid && r_s2.last_k;
        end
    end

    // low product bits are the same for signed and unsigned operands
    always_ff @(posedge i_clk) begin
        if (r_s1.valid) begin
            r_prod <= DATA_W'(w_a_rdata * w_b_rdata);
        end
        if (r_s2.valid) begin
            r_acc <= w_sum;
        end
        if (r_s2.valid && r_s2.last_k) begin
            r_result.out_row     <= r_s2.i;
            r_result.out_col     <= r_s2.j;
            r_result.out_value   <= w_sum;
            r_result.last_result <= r_s2.last_all;
        end
    end

    assign o_status.pipe_busy = r_s1.valid || r_s2.valid;
    assign o_strobe           = r_strobe;
    assign o_result           = r_result;

endmodule

`default_nettype wire

@@ design/square_matrix_multiply.sv @@
// ----------------------------------------------------------------------------
// square_matrix_multiply
// Square integer matrix multiplier, element loads and row-major product walk.
// Load requests are accepted one per cycle while not busy and may follow back to back.
// A compute request steps k for each product element through one shared
// multiply-accumulate fed by the command register, RAM read and product
// register; one result per product element, and busy holds until the last one.
// Synchronous reset clears the controller and sets size to 8; stores keep data.
// ----------------------------------------------------------------------------
`default_nettype none

module square_matrix_multiply (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire smm_pkg::t_in               i_in,
    input  wire logic                       i_cfg_we,
    input  wire logic [smm_pkg::SIZE_W-1:0] i_cfg_wdata,
    output logic                            o_strobe,
    output smm_pkg::t_out                   o_result
);

    import smm_pkg::*;

    t_load_cmd  w_load;
    t_cmd       w_cmd;
    t_dp_status w_status;

    smm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_kind      (i_in.kind),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_status    (w_status),
        .o_busy      (busy),
        .o_load      (w_load),
        .o_cmd       (w_cmd)
    );

    smm_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_in     (i_in),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

`ifndef SYNTHESIS
    a_strobe_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe outside a compute request");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last_result) |=> (!o_strobe && !busy))
        else $error("activity after the last result");

    a_busy_needs_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy raised without a request");

    a_no_load_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !(w_load.we_a || w_load.we_b))
        else $error("matrix write during a compute request");
`endif

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the square matrix multiplier. Loads elements of A
// and B, computes products at sizes from 0 to 15, and compares every product
// element against a behavioral predictor. Request gaps are random, and a
// tracked write mask keeps computes away from elements that were never loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import smm_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int TARGET_ITEMS = 300;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_in i_in = '0;
    logic i_cfg_we = 1'b0;
    logic [SIZE_W-1:0] i_cfg_wdata = '0;
    logic o_strobe;
    t_out o_result;

    square_matrix_multiply dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [DATA_W-1:0] mat_a [CELLS];
    logic [DATA_W-1:0] mat_b [CELLS];
    logic [SIZE_W-1:0] size_reg = SIZE_RESET;
    t_out product_q [$];

    // stimulus state
    t_in request_q [$];
    bit a_written [CELLS];
    bit b_written [CELLS];
    int stim_count = 0;
    bit no_gaps = 1'b0;
    int idle_left = 0;
    int fail_count = 0;
    int unsigned cycle_count = 0;

    function automatic int active_dim(logic [SIZE_W-1:0] s);
        if (s == 0) return 1;
        if (s > MAX_DIM) return MAX_DIM;
        return int'(s);
    endfunction

    function automatic void apply_request(t_in req);
        int n;
        t_out res;
        logic [DATA_W-1:0] acc;
        case (req.kind)
            KIND_LOAD_A: mat_a[{req.elem_row, req.elem_col}] = req.elem_value;
            KIND_LOAD_B: mat_b[{req.elem_row, req.elem_col}] = req.elem_value;
            KIND_COMPUTE: begin
                n = active_dim(size_reg);
                for (int i = 0; i < n; i++) begin
                    for (int j = 0; j < n; j++) begin
                        acc = '0;
                        for (int k = 0; k < n; k++)
                            acc = acc + mat_a[i * MAX_DIM + k] * mat_b[k * MAX_DIM + j];
                        res.out_row     = DIM_W'(i);
                        res.out_col     = DIM_W'(j);
                        res.out_value   = acc;
                        res.last_result = (i == n - 1) && (j == n - 1);
                        product_q.push_back(res);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return '0;
            4: return 32'd1;
            5, 6: return 32'($urandom_range(0, 200)) - 32'd100;
            default: return $urandom;
        endcase
    endfunction

    function automatic void push_item(logic [KIND_W-1:0] kind, int row, int col,
                                      logic [DATA_W-1:0] value);
        t_in req;
        req.kind       = kind;
        req.elem_row   = DIM_W'(row);
        req.elem_col   = DIM_W'(col);
        req.elem_value = value;
        request_q.push_back(req);
        if (kind == KIND_LOAD_A) a_written[row * MAX_DIM + col] = 1'b1;
        if (kind == KIND_LOAD_B) b_written[row * MAX_DIM + col] = 1'b1;
        if (kind != KIND_UNUSED) stim_count++;
    endfunction

    // load every element of the active region that has not been written yet
    function automatic void fill_region(int n);
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
                if (!a_written[r * MAX_DIM + c]) push_item(KIND_LOAD_A, r, c, rand_value());
                if (!b_written[r * MAX_DIM + c]) push_item(KIND_LOAD_B, r, c, rand_value());
            end
        end
    endfunction

    task automatic wait_idle();
        @(negedge i_clk);
        while (request_q.size() != 0 || start || busy || product_q.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_size(logic [SIZE_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        size_reg = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // driver
    always @(posedge i_clk) begin : driver
        t_in next_item;
        logic next_start;
        if (!i_rst_n) begin
            start     <= 1'b0;
            idle_left <= 0;
        end else begin
            next_item  = i_in;
            next_start = start;
            if (start && !busy) begin
                apply_request(i_in);
                next_start = 1'b0;
            end
            if (!next_start) begin
                if (idle_left > 0) begin
                    idle_left <= idle_left - 1;
                end else if (request_q.size() > 0) begin
                    next_item  = request_q.pop_front();
                    next_start = 1'b1;
                    idle_left <= pick_gap();
                end
            end
            start <= next_start;
            i_in  <= next_item;
        end
    end

    // monitor
    always @(posedge i_clk) begin : monitor
        t_out want;
        if (i_rst_n && o_strobe) begin
            if (product_q.size() == 0) begin
                $error("unexpected result row %0d col %0d value %0d",
                       o_result.out_row, o_result.out_col, o_result.out_value);
                fail_count++;
            end else begin
                want = product_q.pop_front();
                if (o_result.out_row !== want.out_row) begin
                    $error("out_row expected %0d got %0d", want.out_row, o_result.out_row);
                    fail_count++;
                end
                if (o_result.out_col !== want.out_col) begin
                    $error("out_col expected %0d got %0d", want.out_col, o_result.out_col);
                    fail_count++;
                end
                if (o_result.out_value !== want.out_value) begin
                    $error("out_value expected %0d got %0d", want.out_value,
                           o_result.out_value);
                    fail_count++;
                end
                if (o_result.last_result !== want.last_result) begin
                    $error("last_result expected %0d got %0d", want.last_result,
                           o_result.last_result);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        logic [SIZE_W-1:0] sizes [$];
        logic [SIZE_W-1:0] sz;
        int n;
        int count;
        int r;
        sizes = '{4'd15, 4'd8, 4'd1, 4'd0, 4'd3, 4'd9, 4'd5};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        size_reg = SIZE_RESET;

        // directed: wrap extremes at size one, unused kind, far corner loads
        write_size(4'd1);
        push_item(KIND_LOAD_A, 0, 0, 32'h8000_0000);
        push_item(KIND_LOAD_B, 0, 0, 32'hffff_ffff);
        push_item(KIND_COMPUTE, 0, 0, '0);
        push_item(KIND_LOAD_A, 0, 0, 32'h7fff_ffff);
        push_item(KIND_LOAD_B, 0, 0, 32'h7fff_ffff);
        push_item(KIND_COMPUTE, 7, 7, 32'hffff_ffff);
        push_item(KIND_UNUSED, 7, 7, 32'hffff_ffff);
        push_item(KIND_COMPUTE, 0, 0, '0);
        push_item(KIND_LOAD_A, 7, 7, 32'hffff_ffff);
        push_item(KIND_LOAD_B, 7, 7, 32'h8000_0000);
        push_item(KIND_COMPUTE, 0, 0, '0);
        wait_idle();
        // size zero behaves as size one
        write_size(4'd0);
        push_item(KIND_COMPUTE, 0, 0, '0);
        push_item(KIND_LOAD_A, 0, 0, '0);
        push_item(KIND_COMPUTE, 0, 0, '0);
        wait_idle();
        write_size(4'd2);
        fill_region(2);
        push_item(KIND_COMPUTE, 0, 0, '0);
        wait_idle();

        // random phases, extremes of the size first
        while (stim_count < TARGET_ITEMS + 20) begin
            if (sizes.size() > 0) sz = sizes.pop_front();
            else if ($urandom_range(0, 9) < 7) sz = SIZE_W'($urandom_range(1, 4));
            else sz = SIZE_W'($urandom_range(0, 15));
            no_gaps = ($urandom_range(0, 3) == 0);
            write_size(sz);
            n = active_dim(sz);
            fill_region(n);
            count = $urandom_range(10, 30);
            for (int i = 0; i < count; i++) begin
                r = $urandom_range(0, 99);
                if (r < 55)
                    push_item(r[0] ? KIND_LOAD_B : KIND_LOAD_A, $urandom_range(0, n - 1),
                              $urandom_range(0, n - 1), rand_value());
                else if (r < 65)
                    push_item(r[0] ? KIND_LOAD_B : KIND_LOAD_A, $urandom_range(0, 7),
                              $urandom_range(0, 7), rand_value());
                else if (r < 72)
                    push_item(KIND_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7),
                              $urandom);
                else
                    push_item(KIND_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7),
                              $urandom);
            end
            push_item(KIND_COMPUTE, 0, 0, '0);
            wait_idle();
        end

        repeat (20) @(negedge i_clk);
        if (product_q.size() != 0) begin
            $error("%0d product elements never arrived", product_q.size());
        end
        if (fail_count == 0 && product_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
design/smm_pkg.sv
design/smm_ram.sv
design/smm_ctrl.sv
design/smm_datapath.sv
design/square_matrix_multiply.sv
tb/tb_top.sv
